// File: hdl/wear_share_tier_and_stream_placement_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wear share placement unit
// Concurrent checks on the rising clock edge, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef WEAR_SHARE_TIER_AND_STREAM_PLACEMENT_UNIT_DEFINES_SVH
`define WEAR_SHARE_TIER_AND_STREAM_PLACEMENT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define WSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSP_ASSERT_NOW(lbl, ante, cons)
`define WSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared constants and types of the wear share placement unit.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam logic [63:0] HASH_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_OFFSET = 64'd11;
  localparam logic [63:0] HASH_MUL1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] HASH_MUL2   = 64'h94D049BB133111EB;
  localparam int unsigned SHIFT1 = 30;
  localparam int unsigned SHIFT2 = 27;
  localparam int unsigned SHIFT3 = 31;

  localparam logic [1:0] REG_SLC_SHARE = 2'd0;
  localparam logic [1:0] REG_SLC_COUNT = 2'd1;
  localparam logic [1:0] REG_TLC_COUNT = 2'd2;

  localparam logic TIER_SLC = 1'b0;
  localparam logic TIER_TLC = 1'b1;

  // number of remainder stages, four dividend bits each
  localparam int unsigned MOD_STAGES = 16;

  typedef struct packed {
    logic        tier;
    logic [15:0] cnt;
  } place_t;

endpackage

// File: hdl/wsp_hash.sv
// ----------------------------------------------------------------------------
// wsp_hash
// Three stage splitmix64 finalizer, multiplies cut into 32x32 partials.
// ----------------------------------------------------------------------------
module wsp_hash (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] key,
  output logic [63:0] hash
);

  logic [63:0] r0, x0;
  logic [63:0] p1_ll_r;
  logic [31:0] p1_hl_r, p1_lh_r;
  logic [63:0] y1, z1;
  logic [63:0] p2_ll_r;
  logic [31:0] p2_hl_r, p2_lh_r;
  logic [63:0] y2;
  logic [63:0] hash_r;

  assign r0 = {32'd0, key} + wsp_pkg::HASH_GOLDEN + wsp_pkg::HASH_OFFSET;
  assign x0 = r0 ^ (r0 >> wsp_pkg::SHIFT1);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ll_r <= 64'(x0[31:0] * wsp_pkg::HASH_MUL1[31:0]);
      p1_hl_r <= 32'(x0[63:32] * wsp_pkg::HASH_MUL1[31:0]);
      p1_lh_r <= 32'(x0[31:0] * wsp_pkg::HASH_MUL1[63:32]);
    end
  end

  assign y1 = p1_ll_r + {p1_hl_r + p1_lh_r, 32'd0};
  assign z1 = y1 ^ (y1 >> wsp_pkg::SHIFT2);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ll_r <= 64'(z1[31:0] * wsp_pkg::HASH_MUL2[31:0]);
      p2_hl_r <= 32'(z1[63:32] * wsp_pkg::HASH_MUL2[31:0]);
      p2_lh_r <= 32'(z1[31:0] * wsp_pkg::HASH_MUL2[63:32]);
    end
  end

  assign y2 = p2_ll_r + {p2_hl_r + p2_lh_r, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      hash_r <= y2 ^ (y2 >> wsp_pkg::SHIFT3);
    end
  end

  assign hash = hash_r;

endmodule

// File: hdl/wsp_mod.sv
// ----------------------------------------------------------------------------
// wsp_mod
// Pipelined restoring remainder of a 64-bit hash by a 16-bit stream count.
// ----------------------------------------------------------------------------
module wsp_mod (
  input  logic            clk,
  input  logic            en,
  input  logic [63:0]     dvd,
  input  wsp_pkg::place_t place,
  output logic [15:0]     rem,
  output wsp_pkg::place_t place_out
);

  localparam int unsigned N = wsp_pkg::MOD_STAGES;

  logic [15:0]     rem_r   [N];
  logic [63:0]     dvd_r   [N];
  wsp_pkg::place_t place_r [N];

  // four shift and subtract steps on the running remainder
  function automatic logic [15:0] step4(input logic [15:0] r, input logic [3:0] b,
                                        input logic [15:0] c);
    logic [16:0] t;
    logic [15:0] q;
    q = r;
    for (int j = 3; j >= 0; j--) begin
      t = {q, b[j]};
      if (t >= {1'b0, c}) t = t - {1'b0, c};
      q = t[15:0];
    end
    return q;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [15:0]     rem_in;
    logic [63:0]     dvd_in;
    wsp_pkg::place_t place_in;
    if (k == 0) begin : g_first
      assign rem_in   = 16'd0;
      assign dvd_in   = dvd;
      assign place_in = place;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign dvd_in   = dvd_r[k-1];
      assign place_in = place_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= step4(rem_in, dvd_in[63:60], place_in.cnt);
        dvd_r[k]   <= {dvd_in[59:0], 4'd0};
        place_r[k] <= place_in;
      end
    end
  end

  // a zero count gives stream zero
  assign rem       = (place_r[N-1].cnt == 16'd0) ? 16'd0 : rem_r[N-1];
  assign place_out = place_r[N-1];

endmodule

// File: hdl/wear_share_tier_and_stream_placement_unit.sv
// ----------------------------------------------------------------------------
// wear_share_tier_and_stream_placement_unit
// Picks the flash tier and write stream of each write.
// ----------------------------------------------------------------------------
// One item enters per cycle while the pipeline advances; each item passes
// four stages of tier compare and hash multiplies followed by sixteen
// remainder stages that each retire four bits of the 64-bit hash. The
// whole pipeline holds while a finished result waits on out_ready. Write the
// registers over the APB port only while no item is in flight.
// ----------------------------------------------------------------------------
`include "wear_share_tier_and_stream_placement_unit_defines.svh"

module wear_share_tier_and_stream_placement_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_slc_written_bytes,
  input  logic [47:0] in_tlc_written_bytes,
  input  logic [31:0] in_write_size,
  input  logic [31:0] in_affinity_id,
  input  logic [31:0] in_segment_endpoint,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tier_select,
  output logic [15:0] out_stream_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH = 4 + wsp_pkg::MOD_STAGES;

  logic [15:0] share_r, slc_cnt_r, tlc_cnt_r;
  logic        cfg_we;
  logic        adv;
  logic [DEPTH-1:0] v_r;

  logic [48:0] sum_slc_r, sum_tlc_r;
  logic [31:0] key_r;
  logic [65:0] lp_r, rp_r;
  logic        pick_r;
  wsp_pkg::place_t place_r, place_out;
  logic [63:0] hash;
  logic [15:0] rem;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      share_r   <= 16'd32768;
      slc_cnt_r <= 16'd1;
      tlc_cnt_r <= 16'd1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        wsp_pkg::REG_SLC_SHARE: share_r   <= pwdata[15:0];
        wsp_pkg::REG_SLC_COUNT: slc_cnt_r <= pwdata[15:0];
        wsp_pkg::REG_TLC_COUNT: tlc_cnt_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wsp_pkg::REG_SLC_SHARE: prdata = {16'd0, share_r};
      wsp_pkg::REG_SLC_COUNT: prdata = {16'd0, slc_cnt_r};
      wsp_pkg::REG_TLC_COUNT: prdata = {16'd0, tlc_cnt_r};
      default:                prdata = 32'd0;
    endcase
  end

  // pipeline control: advance everything unless the result is stuck
  assign adv      = !v_r[DEPTH-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  // stage A: sums and key
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_slc_r <= {1'b0, in_slc_written_bytes} + {17'd0, in_write_size};
      sum_tlc_r <= {1'b0, in_tlc_written_bytes} + {17'd0, in_write_size};
      key_r     <= (in_affinity_id != 32'd0) ? in_affinity_id : in_segment_endpoint;
    end
  end

  // stage B: weighted products, stage C: compare, stage D: tier and count
  always_ff @(posedge clk) begin
    if (adv) begin
      lp_r    <= sum_slc_r * (17'h10000 - {1'b0, share_r});
      rp_r    <= sum_tlc_r * {1'b0, share_r};
      pick_r  <= (lp_r <= rp_r);
      place_r <= '{tier: pick_r ? wsp_pkg::TIER_SLC : wsp_pkg::TIER_TLC,
                   cnt:  pick_r ? slc_cnt_r : tlc_cnt_r};
    end
  end

  wsp_hash u_hash (
    .clk  (clk),
    .en   (adv),
    .key  (key_r),
    .hash (hash)
  );

  wsp_mod u_mod (
    .clk       (clk),
    .en        (adv),
    .dvd       (hash),
    .place     (place_r),
    .rem       (rem),
    .place_out (place_out)
  );

  assign out_valid        = v_r[DEPTH-1];
  assign out_tier_select  = place_out.tier;
  assign out_stream_index = rem;

  `WSP_ASSERT_NOW(a_idx_range, out_valid && place_out.cnt != 16'd0, rem < place_out.cnt)
  `WSP_ASSERT_NEXT(a_enter, in_valid && in_ready, v_r[0])
  `WSP_ASSERT_NEXT(a_tier, adv && v_r[2], place_r.tier == !$past(pick_r))

endmodule
